// File: rtl/core/tgc_pkg.sv
package tgc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int TOP_ZONE_DEF = 80;
    localparam int BOTTOM_ZONE_DEF = 80;

    // configuration register indexes
    localparam logic [2:0] REG_SCREEN_W = 3'd0;
    localparam logic [2:0] REG_SCREEN_H = 3'd1;
    localparam logic [2:0] REG_EDGE_W = 3'd2;
    localparam logic [2:0] REG_SWIPE_DIST = 3'd3;
    localparam logic [2:0] REG_TAP_DIST = 3'd4;
    localparam logic [2:0] REG_SWIPE_SPEED = 3'd5;
    localparam logic [2:0] REG_LONG_MS = 3'd6;
    localparam logic [2:0] REG_DTAP_MS = 3'd7;

    // gesture codes
    localparam logic [2:0] G_TAP = 3'd0;
    localparam logic [2:0] G_DTAP = 3'd1;
    localparam logic [2:0] G_LONG = 3'd2;
    localparam logic [2:0] G_UP = 3'd3;
    localparam logic [2:0] G_DOWN = 3'd4;
    localparam logic [2:0] G_LEFT = 3'd5;
    localparam logic [2:0] G_RIGHT = 3'd6;

    // zone codes
    localparam logic [2:0] Z_TOP = 3'd0;
    localparam logic [2:0] Z_BOTTOM = 3'd1;
    localparam logic [2:0] Z_LEFT = 3'd2;
    localparam logic [2:0] Z_RIGHT = 3'd3;
    localparam logic [2:0] Z_MIDDLE = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the input item for the front checks
        logic flush;       // move the timed-out held tap into the result
        logic root_start;  // load the square root unit
        logic root_step;   // one square root iteration
        logic div_start;   // load the divider
        logic div_step;    // one divider iteration
        logic finish;      // classify and update state
    } tgc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic timeout;     // held tap timed out
        logic do_release;  // a release with active contact
        logic root_done;
        logic div_done;
        logic emit;        // finish produced a result item
    } tgc_stat_t;

endpackage

// File: rtl/core/tgc_if.sv
interface tgc_in_if #(parameter int COORD_BITS = 12);
    logic valid;
    logic ready;
    logic [31:0] now_ms;
    logic contact_present;
    logic press_edge;
    logic release_edge;
    logic [COORD_BITS-1:0] touch_x;
    logic [COORD_BITS-1:0] touch_y;
    modport source (output valid, now_ms, contact_present, press_edge, release_edge,
                    touch_x, touch_y, input ready);
    modport sink (input valid, now_ms, contact_present, press_edge, release_edge,
                  touch_x, touch_y, output ready);
endinterface

interface tgc_out_if #(parameter int COORD_BITS = 12);
    logic valid;
    logic ready;
    logic [2:0] gesture_kind;
    logic [COORD_BITS-1:0] begin_x;
    logic [COORD_BITS-1:0] begin_y;
    logic [COORD_BITS-1:0] finish_x;
    logic [COORD_BITS-1:0] finish_y;
    logic [31:0] hold_ms;
    logic [2:0] zone;
    logic [15:0] speed_q8;
    modport source (output valid, gesture_kind, begin_x, begin_y, finish_x, finish_y,
                    hold_ms, zone, speed_q8, input ready);
    modport sink (input valid, gesture_kind, begin_x, begin_y, finish_x, finish_y,
                  hold_ms, zone, speed_q8, output ready);
endinterface

// File: rtl/core/touch_gesture_classifier_core.sv
// order: a timed-out held tap is flushed to the output from the check state; a sample with
// no result returns to idle after the check; a release runs the check, root, divide, finish
// and emit states, with the bit-serial square root (COORD_BITS+1 steps) and divider (COORD_BITS+9 steps)
// throughput: one item at a time; the next item is taken once any result item has left
// reset: asynchronous active low; config to defaults, gesture state cleared
module touch_gesture_classifier_core
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TOP_ZONE_HEIGHT = TOP_ZONE_DEF,
    parameter int BOTTOM_ZONE_HEIGHT = BOTTOM_ZONE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    tgc_in_if.sink      in_ch,
    tgc_out_if.source   out_ch
);

    tgc_cmd_t  cmd;
    tgc_stat_t stat;
    logic      out_load;
    logic      out_valid_reg;

    logic [2:0]            r_kind, r_zone;
    logic [COORD_BITS-1:0] r_bx, r_by, r_fx, r_fy;
    logic [31:0]           r_hold;
    logic [15:0]           r_speed;

    tgc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_busy (out_valid_reg),
        .out_load (out_load),
        .cmd      (cmd),
        .stat     (stat)
    );

    tgc_datapath #(
        .COORD_BITS         (COORD_BITS),
        .TOP_ZONE_HEIGHT    (TOP_ZONE_HEIGHT),
        .BOTTOM_ZONE_HEIGHT (BOTTOM_ZONE_HEIGHT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .now_ms          (in_ch.now_ms),
        .contact_present (in_ch.contact_present),
        .press_edge      (in_ch.press_edge),
        .release_edge    (in_ch.release_edge),
        .touch_x         (in_ch.touch_x),
        .touch_y         (in_ch.touch_y),
        .cmd             (cmd),
        .stat            (stat),
        .r_kind          (r_kind),
        .r_bx            (r_bx),
        .r_by            (r_by),
        .r_fx            (r_fx),
        .r_fy            (r_fy),
        .r_hold          (r_hold),
        .r_zone          (r_zone),
        .r_speed         (r_speed)
    );

    // output valid; payload is held in the datapath result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.gesture_kind = r_kind;
    assign out_ch.begin_x = r_bx;
    assign out_ch.begin_y = r_by;
    assign out_ch.finish_x = r_fx;
    assign out_ch.finish_y = r_fy;
    assign out_ch.hold_ms = r_hold;
    assign out_ch.zone = r_zone;
    assign out_ch.speed_q8 = r_speed;

endmodule

// File: rtl/core/tgc_ctrl.sv
module tgc_ctrl
    import tgc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_busy,
    output logic      out_load,
    output tgc_cmd_t  cmd,
    input  tgc_stat_t stat
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_ROOT  = 6'b000100,
        S_DIV   = 6'b001000,
        S_FIN   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // accept only in idle and when the output register is free
    assign in_ready = (state_reg == S_IDLE) && !out_busy;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.timeout)
                begin
                    cmd.flush = 1'b1;
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.do_release)
                begin
                    cmd.root_start = 1'b1;
                    state_next = S_ROOT;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (stat.root_done)
                begin
                    cmd.root_step = 1'b0;
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    cmd.div_step = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                out_load = stat.emit;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/core/tgc_datapath.sv
module tgc_datapath
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TOP_ZONE_HEIGHT = TOP_ZONE_DEF,
    parameter int BOTTOM_ZONE_HEIGHT = BOTTOM_ZONE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic [31:0]           now_ms,
    input  logic                  contact_present,
    input  logic                  press_edge,
    input  logic                  release_edge,
    input  logic [COORD_BITS-1:0] touch_x,
    input  logic [COORD_BITS-1:0] touch_y,
    input  tgc_cmd_t              cmd,
    output tgc_stat_t             stat,
    output logic [2:0]            r_kind,
    output logic [COORD_BITS-1:0] r_bx,
    output logic [COORD_BITS-1:0] r_by,
    output logic [COORD_BITS-1:0] r_fx,
    output logic [COORD_BITS-1:0] r_fy,
    output logic [31:0]           r_hold,
    output logic [2:0]            r_zone,
    output logic [15:0]           r_speed
);

    localparam int CB = COORD_BITS;
    localparam int SQ = 2 * CB + 1;          // width of dx*dx+dy*dy
    localparam int RB = CB + 1;              // width of the root
    localparam int RSTEPS = (SQ + 1) / 2;
    localparam int RCW = $clog2(RSTEPS + 1);
    localparam int NB = RB + 8;              // dividend width
    localparam int DCW = $clog2(NB + 1);
    localparam int ZW = 18;                  // signed zone compare width

    // configuration registers
    logic [11:0] scr_w_reg, scr_h_reg, edge_w_reg;
    logic [12:0] swipe_dist_reg;
    logic [10:0] tap_dist_reg;
    logic [15:0] swipe_speed_reg, long_ms_reg, dtap_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= 12'd540;
            scr_h_reg <= 12'd960;
            edge_w_reg <= 12'd60;
            swipe_dist_reg <= 13'd50;
            tap_dist_reg <= 11'd20;
            swipe_speed_reg <= 16'd77;
            long_ms_reg <= 16'd800;
            dtap_ms_reg <= 16'd300;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCREEN_W:    scr_w_reg <= cfg_data[11:0];
                REG_SCREEN_H:    scr_h_reg <= cfg_data[11:0];
                REG_EDGE_W:      edge_w_reg <= cfg_data[11:0];
                REG_SWIPE_DIST:  swipe_dist_reg <= cfg_data[12:0];
                REG_TAP_DIST:    tap_dist_reg <= cfg_data[10:0];
                REG_SWIPE_SPEED: swipe_speed_reg <= cfg_data;
                REG_LONG_MS:     long_ms_reg <= cfg_data;
                REG_DTAP_MS:     dtap_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // gesture state
    logic          active_reg;
    logic [CB-1:0] px_reg, py_reg, lx_reg, ly_reg, tx_reg, ty_reg;
    logic [31:0]   ptime_reg, ttime_reg;
    logic          pend_reg;

    // captured item
    logic [31:0]   now_reg;
    logic          pres_reg, prs_reg, rel_reg;
    logic [CB-1:0] x_reg, y_reg;

    // working registers
    logic [SQ-1:0] rv_reg;
    logic [SQ:0]   rres_reg, rbit_reg;
    logic [RCW-1:0] rcnt_reg;
    logic [NB-1:0] dq_reg;
    logic [31:0]   drem_reg;
    logic [DCW-1:0] dcnt_reg;
    logic          emit_reg;

    // effective start / latest after the sample's press/move
    logic          new_press;
    logic [CB-1:0] sx, sy, ex, ey;
    logic [31:0]   st;
    assign new_press = prs_reg && !active_reg;
    assign sx = new_press ? x_reg : px_reg;
    assign sy = new_press ? y_reg : py_reg;
    assign ex = x_reg;
    assign ey = y_reg;
    assign st = new_press ? now_reg : ptime_reg;

    logic [31:0] tdiff, dur;
    assign tdiff = now_reg - ttime_reg;
    assign dur = now_reg - st;
    assign stat.timeout = pend_reg && (tdiff > {16'd0, dtap_ms_reg});
    assign stat.do_release = pres_reg && rel_reg && (active_reg || prs_reg);
    assign stat.root_done = (rcnt_reg == '0);
    assign stat.div_done = (dcnt_reg == '0);
    assign stat.emit = emit_reg;

    // displacement
    logic signed [CB:0] dxs, dys;
    logic [CB-1:0] adx, ady;
    assign dxs = $signed({1'b0, ex}) - $signed({1'b0, sx});
    assign dys = $signed({1'b0, ey}) - $signed({1'b0, sy});
    assign adx = dxs[CB] ? CB'(-dxs) : dxs[CB-1:0];
    assign ady = dys[CB] ? CB'(-dys) : dys[CB-1:0];

    // zone of a point
    function automatic logic [2:0] zone_f(input logic [CB-1:0] zx, input logic [CB-1:0] zy,
                                         input logic [11:0] sw, input logic [11:0] sh,
                                         input logic [11:0] ew);
        logic signed [ZW-1:0] fx, fy, bh, rw;
        fx = ZW'(zx);
        fy = ZW'(zy);
        bh = $signed(ZW'(sh)) - $signed(ZW'(BOTTOM_ZONE_HEIGHT));
        rw = $signed(ZW'(sw)) - $signed(ZW'(ew));
        if (fy < $signed(ZW'(TOP_ZONE_HEIGHT))) return Z_TOP;
        if (fy > bh) return Z_BOTTOM;
        if (fx < $signed(ZW'(ew))) return Z_LEFT;
        if (fx > rw) return Z_RIGHT;
        return Z_MIDDLE;
    endfunction

    // square root step
    logic [SQ:0] rsum;
    assign rsum = rres_reg + rbit_reg;
    // divider step (restoring, one quotient bit a cycle)
    logic [32:0] dshift;
    logic [32:0] dtrial;
    assign dshift = {drem_reg, dq_reg[NB-1]};
    assign dtrial = dshift - {1'b0, dur};

    logic [RB-1:0] travel;
    assign travel = rres_reg[RB-1:0];

    // classification
    logic [NB-1:0] dist256;
    logic [47:0]   spd_prod;
    logic          swipe, is_tap, lim_ok;
    logic [15:0]   speed;
    logic [12:0]   lim3;
    logic [CB-1:0] ptx, pty;
    assign dist256 = {travel, 8'd0};
    assign spd_prod = 48'(swipe_speed_reg) * 48'(dur);
    assign swipe = (32'(travel) >= 32'(swipe_dist_reg))
                   && !(dur != 0 && 48'(dist256) < spd_prod);
    assign is_tap = 32'(travel) < 32'(tap_dist_reg);
    assign speed = (dur == 0) ? 16'd0 : ((|dq_reg[NB-1:16]) ? 16'hFFFF : dq_reg[15:0]);
    assign lim3 = 13'(tap_dist_reg) * 13'd3;
    assign ptx = (ex >= tx_reg) ? ex - tx_reg : tx_reg - ex;
    assign pty = (ey >= ty_reg) ? ey - ty_reg : ty_reg - ey;
    assign lim_ok = (32'(ptx) < 32'(lim3)) && (32'(pty) < 32'(lim3));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg <= 1'b0;
            px_reg <= '0; py_reg <= '0; lx_reg <= '0; ly_reg <= '0;
            tx_reg <= '0; ty_reg <= '0;
            ptime_reg <= '0; ttime_reg <= '0;
            rv_reg <= '0; rres_reg <= '0; rbit_reg <= '0;
            rcnt_reg <= '0;
            dq_reg <= '0; drem_reg <= '0;
            dcnt_reg <= '0;
            emit_reg <= 1'b0;
            r_kind <= G_TAP;
            r_bx <= '0; r_by <= '0; r_fx <= '0; r_fy <= '0;
            r_hold <= '0; r_zone <= Z_TOP; r_speed <= '0;
        end
        else
        begin
            if (cmd.capture)
                emit_reg <= 1'b0;
            if (cmd.root_start)
            begin
                rv_reg <= SQ'(adx) * SQ'(adx) + SQ'(ady) * SQ'(ady);
                rres_reg <= '0;
                rbit_reg <= (SQ+1)'(1) << (2 * (RSTEPS - 1));
                rcnt_reg <= RCW'(RSTEPS);
            end
            if (cmd.root_step)
            begin
                if ((SQ+1)'(rv_reg) >= rsum)
                begin
                    rv_reg <= SQ'((SQ+1)'(rv_reg) - rsum);
                    rres_reg <= (rres_reg >> 1) + rbit_reg;
                end
                else
                    rres_reg <= rres_reg >> 1;
                rbit_reg <= rbit_reg >> 2;
                rcnt_reg <= rcnt_reg - 1'b1;
            end
            if (cmd.div_start)
            begin
                dq_reg <= dist256;
                drem_reg <= '0;
                dcnt_reg <= DCW'(NB);
            end
            if (cmd.div_step)
            begin
                if (!dtrial[32])
                begin
                    drem_reg <= dtrial[31:0];
                    dq_reg <= {dq_reg[NB-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dshift[31:0];
                    dq_reg <= {dq_reg[NB-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            if (cmd.finish)
            begin
                if (!pres_reg)
                    active_reg <= 1'b0;
                else if (!stat.do_release)
                begin
                    if (new_press)
                    begin
                        active_reg <= 1'b1;
                        px_reg <= x_reg; py_reg <= y_reg;
                        ptime_reg <= now_reg;
                    end
                    if (new_press || active_reg)
                    begin
                        lx_reg <= x_reg; ly_reg <= y_reg;
                    end
                end
                else
                begin
                    active_reg <= 1'b0;
                    px_reg <= sx; py_reg <= sy; ptime_reg <= st;
                    lx_reg <= ex; ly_reg <= ey;
                    r_bx <= sx; r_by <= sy; r_fx <= ex; r_fy <= ey;
                    r_hold <= dur;
                    r_zone <= zone_f(sx, sy, scr_w_reg, scr_h_reg, edge_w_reg);
                    r_speed <= speed;
                    if (swipe)
                    begin
                        pend_reg <= 1'b0;
                        emit_reg <= 1'b1;
                        if (adx > ady)
                            r_kind <= dxs[CB] ? G_LEFT : G_RIGHT;
                        else
                            r_kind <= (!dys[CB] && dys != 0) ? G_DOWN : G_UP;
                    end
                    else if (is_tap)
                    begin
                        if (32'(dur) >= 32'(long_ms_reg))
                        begin
                            pend_reg <= 1'b0;
                            emit_reg <= 1'b1;
                            r_kind <= G_LONG;
                        end
                        else if (pend_reg && lim_ok)
                        begin
                            pend_reg <= 1'b0;
                            emit_reg <= 1'b1;
                            r_kind <= G_DTAP;
                        end
                        else
                        begin
                            if (pend_reg)
                            begin
                                emit_reg <= 1'b1;
                                r_kind <= G_TAP;
                                r_bx <= tx_reg; r_by <= ty_reg;
                                r_fx <= tx_reg; r_fy <= ty_reg;
                                r_hold <= '0;
                                r_speed <= '0;
                                r_zone <= zone_f(tx_reg, ty_reg, scr_w_reg, scr_h_reg,
                                                 edge_w_reg);
                            end
                            pend_reg <= 1'b1;
                            tx_reg <= ex; ty_reg <= ey;
                            ttime_reg <= now_reg;
                        end
                    end
                end
            end
            else if (cmd.flush)
            begin
                // timeout flushes the held tap directly into the result
                pend_reg <= 1'b0;
                r_kind <= G_TAP;
                r_bx <= tx_reg; r_by <= ty_reg; r_fx <= tx_reg; r_fy <= ty_reg;
                r_hold <= '0; r_speed <= '0;
                r_zone <= zone_f(tx_reg, ty_reg, scr_w_reg, scr_h_reg, edge_w_reg);
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg <= now_ms;
            pres_reg <= contact_present;
            prs_reg <= press_edge;
            rel_reg <= release_edge;
            x_reg <= touch_x;
            y_reg <= touch_y;
        end
    end

endmodule
